// ===== design/rsw_pkg.sv =====
// Package for the RSI Wilder smoothing core: shared types, widths and constants.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package rsw_pkg;

    // Default parameter values.
    localparam int PRICE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Period register: reset value and smallest period in effect.
    localparam int          PERIOD_W   = 8;
    localparam logic [7:0]  PERIOD_RST = 8'd14;
    localparam logic [7:0]  PERIOD_MIN = 8'd2;

    // The arithmetic is 64-bit and wraps; the averages keep 56 bits.
    localparam int NUM_W = 64;
    localparam int AVG_W = 56;

    // Digit divider for the period: four quotient bits per cycle.
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_STEPS      = NUM_W / DIV_RADIX_BITS;

    // Ratio divider: the quotient never exceeds 15 bits.
    localparam int RSI_Q_BITS = 15;
    localparam logic [RSI_Q_BITS-1:0] RSI_FULL = 15'd25600;
    localparam int DEN_W = AVG_W + 1;
    localparam int DSH_W = DEN_W + RSI_Q_BITS - 1;

    // Shared step counter for both dividers.
    localparam int CNT_W = 4;

    // Class of one price sample, decided by the front end.
    typedef enum logic [1:0] {
        KIND_FIRST,
        KIND_ACCUM,
        KIND_FINAL,
        KIND_SMOOTH
    } t_kind;

    localparam int KIND_W = $bits(t_kind);

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_RMUL,
        ST_RDIV,
        ST_PUSH
    } t_state;

    // Status of a queue as seen by its producer and consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== design/rsi_wilder_smoothing_core.sv =====
// Channel     | Direction | Signals                        | Transaction when
// ------------+-----------+--------------------------------+--------------------------
// sample      | in        | push, full, i_price            | push && !full
// result      | out       | empty, pop, o_rsi_value/valid  | pop && !empty
// period      | in        | i_cfg_we, i_cfg_data           | i_cfg_we
//
// The back end takes a first sample through the idle and push states and a warm-up sample
// through idle, sum and push; the closing warm-up sample runs the period divider (four bits
// per cycle) and the ratio divider (one bit per cycle) after the sum, a smoothed sample runs
// multiply and add before both, and the ratio divider is skipped when the loss average is zero.
// Reset is synchronous and active low; no clearing pass is needed after it.
// Two-entry queues part the front end from the back end and the back end from the result port.
// Depends on rsw_pkg, rsw_fifo, rsw_front and rsw_back.
`timescale 1ns / 1ps

module rsi_wilder_smoothing_core #(
    parameter int PRICE_BITS = rsw_pkg::PRICE_BITS_DEF,
    parameter int FRAC_BITS  = rsw_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [PRICE_BITS-1:0]            i_price,
    output logic                             empty,
    input  logic                             pop,
    output logic [rsw_pkg::RSI_Q_BITS-1:0]   o_rsi_value,
    output logic                             o_rsi_valid,
    input  logic                             i_cfg_we,
    input  logic [rsw_pkg::PERIOD_W-1:0]     i_cfg_data
);

    localparam int CMD_W = rsw_pkg::KIND_W + 2 * PRICE_BITS;
    localparam int RES_W = rsw_pkg::RSI_Q_BITS + 1;

    logic [rsw_pkg::PERIOD_W-1:0] r_period;
    logic [rsw_pkg::PERIOD_W-1:0] w_period_eff;

    logic                  w_cmd_push;
    rsw_pkg::t_kind        w_front_kind;
    logic [PRICE_BITS-1:0] w_front_gain;
    logic [PRICE_BITS-1:0] w_front_loss;
    logic [CMD_W-1:0]      w_cmd_rd;
    rsw_pkg::t_q_status    w_cmd_status;
    logic                  w_cmd_pop;

    logic                  w_res_push;
    logic [rsw_pkg::RSI_Q_BITS-1:0] w_res_value;
    logic                  w_res_valid;
    rsw_pkg::t_q_status    w_res_status;
    logic [RES_W-1:0]      w_res_rd;

    // Period register; values below the minimum act as the minimum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= rsw_pkg::PERIOD_RST;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_data;
        end
    end

    assign w_period_eff = (r_period < rsw_pkg::PERIOD_MIN) ? rsw_pkg::PERIOD_MIN : r_period;

    // Front end.
    rsw_front #(
        .PRICE_BITS (PRICE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_price    (i_price),
        .i_period   (w_period_eff),
        .i_restart  (i_cfg_we),
        .i_cmd_full (w_cmd_status.full),
        .o_cmd_push (w_cmd_push),
        .o_kind     (w_front_kind),
        .o_gain     (w_front_gain),
        .o_loss     (w_front_loss)
    );

    assign full = w_cmd_status.full;

    // Command queue between the two halves.
    rsw_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_cmd_push),
        .i_data   ({w_front_kind, w_front_gain, w_front_loss}),
        .i_pop    (w_cmd_pop),
        .o_data   (w_cmd_rd),
        .o_status (w_cmd_status)
    );

    // Back end.
    rsw_back #(
        .PRICE_BITS (PRICE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_period     (w_period_eff),
        .i_restart    (i_cfg_we),
        .i_cmd_status (w_cmd_status),
        .i_kind       (rsw_pkg::t_kind'(w_cmd_rd[CMD_W-1 -: rsw_pkg::KIND_W])),
        .i_gain       (w_cmd_rd[2*PRICE_BITS-1:PRICE_BITS]),
        .i_loss       (w_cmd_rd[PRICE_BITS-1:0]),
        .o_cmd_pop    (w_cmd_pop),
        .i_res_status (w_res_status),
        .o_res_push   (w_res_push),
        .o_res_value  (w_res_value),
        .o_res_valid  (w_res_valid)
    );

    // Result queue toward the output port.
    rsw_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_res_push),
        .i_data   ({w_res_valid, w_res_value}),
        .i_pop    (pop),
        .o_data   (w_res_rd),
        .o_status (w_res_status)
    );

    assign empty       = w_res_status.empty;
    assign o_rsi_valid = w_res_rd[RES_W-1];
    assign o_rsi_value = w_res_rd[rsw_pkg::RSI_Q_BITS-1:0];

endmodule

// ===== design/rsw_fifo.sv =====
// Small register queue used between the front end, the back end and the result port.
// Depends on rsw_pkg for the queue status type.
`timescale 1ns / 1ps

module rsw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output rsw_pkg::t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    // Status flags and transaction qualifiers.
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_do_push      = i_push && !o_status.full;
    assign w_do_pop       = i_pop && !o_status.empty;
    assign o_data         = r_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/rsw_front.sv =====
// Front end: takes price samples, splits the change into gain and loss and classifies
// each sample for the back end. Depends on rsw_pkg.
`timescale 1ns / 1ps

module rsw_front #(
    parameter int PRICE_BITS = rsw_pkg::PRICE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [PRICE_BITS-1:0]         i_price,
    input  logic [rsw_pkg::PERIOD_W-1:0]  i_period,
    input  logic                          i_restart,
    input  logic                          i_cmd_full,
    output logic                          o_cmd_push,
    output rsw_pkg::t_kind                o_kind,
    output logic [PRICE_BITS-1:0]         o_gain,
    output logic [PRICE_BITS-1:0]         o_loss
);

    logic [PRICE_BITS-1:0]        r_last_price;
    logic                         r_have_last;
    logic [rsw_pkg::PERIOD_W-1:0] r_count;
    logic [rsw_pkg::PERIOD_W-1:0] w_count_inc;
    logic                         w_accept;

    assign w_accept    = i_push && !i_cmd_full;
    assign o_cmd_push  = w_accept;
    assign w_count_inc = r_count + 1'b1;

    // Gain and loss of the change from the previous price.
    always_comb begin
        o_gain = '0;
        o_loss = '0;
        if (i_price > r_last_price) begin
            o_gain = i_price - r_last_price;
        end else begin
            o_loss = r_last_price - i_price;
        end
    end

    // Classification by warm-up progress.
    always_comb begin
        if (!r_have_last) begin
            o_kind = rsw_pkg::KIND_FIRST;
        end else if (r_count < i_period) begin
            o_kind = (w_count_inc == i_period) ? rsw_pkg::KIND_FINAL : rsw_pkg::KIND_ACCUM;
        end else begin
            o_kind = rsw_pkg::KIND_SMOOTH;
        end
    end

    // Previous price and saturating sample count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_price <= '0;
            r_have_last  <= 1'b0;
            r_count      <= '0;
        end else begin
            if (i_restart) begin
                r_count <= '0;
            end else if (w_accept && r_have_last && (r_count < i_period)) begin
                r_count <= w_count_inc;
            end
            if (w_accept) begin
                r_last_price <= i_price;
                r_have_last  <= 1'b1;
            end
        end
    end

endmodule

// ===== design/rsw_back.sv =====
// Back end: keeps the gain and loss averages, runs the period divider and the ratio
// divider, and produces one result per sample. Depends on rsw_pkg.
`timescale 1ns / 1ps

module rsw_back #(
    parameter int PRICE_BITS = rsw_pkg::PRICE_BITS_DEF,
    parameter int FRAC_BITS  = rsw_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [rsw_pkg::PERIOD_W-1:0]    i_period,
    input  logic                            i_restart,
    input  rsw_pkg::t_q_status              i_cmd_status,
    input  rsw_pkg::t_kind                  i_kind,
    input  logic [PRICE_BITS-1:0]           i_gain,
    input  logic [PRICE_BITS-1:0]           i_loss,
    output logic                            o_cmd_pop,
    input  rsw_pkg::t_q_status              i_res_status,
    output logic                            o_res_push,
    output logic [rsw_pkg::RSI_Q_BITS-1:0]  o_res_value,
    output logic                            o_res_valid
);

    localparam int NW = rsw_pkg::NUM_W;
    localparam int AW = rsw_pkg::AVG_W;
    localparam int PW = rsw_pkg::PERIOD_W;
    localparam int QB = rsw_pkg::RSI_Q_BITS;

    // Four steps of restoring division by the period; returns {remainder, shift word}.
    function automatic logic [PW+NW-1:0] div_step(input logic [NW-1:0] n,
                                                  input logic [PW-1:0] r,
                                                  input logic [PW-1:0] p);
        logic [NW-1:0] nn;
        logic [PW:0]   r9;
        logic [PW-1:0] rr;
        nn = n;
        rr = r;
        for (int k = 0; k < rsw_pkg::DIV_RADIX_BITS; k++) begin
            r9 = {rr, nn[NW-1]};
            nn = {nn[NW-2:0], 1'b0};
            if (r9 >= {1'b0, p}) begin
                r9    = r9 - {1'b0, p};
                nn[0] = 1'b1;
            end
            rr = r9[PW-1:0];
        end
        return {rr, nn};
    endfunction

    rsw_pkg::t_state r_state;
    rsw_pkg::t_state n_state;
    rsw_pkg::t_kind  r_kind;

    logic [NW-1:0]          r_gx;
    logic [NW-1:0]          r_lx;
    logic [AW-1:0]          r_gavg;
    logic [AW-1:0]          r_lavg;
    logic [NW-1:0]          r_gn;
    logic [NW-1:0]          r_ln;
    logic [PW-1:0]          r_gr;
    logic [PW-1:0]          r_lr;
    logic [rsw_pkg::CNT_W-1:0] r_cnt;
    logic [NW-1:0]          r_rnum;
    logic [rsw_pkg::DSH_W-1:0] r_rden;
    logic [QB-1:0]          r_q;
    logic                   r_vld;

    logic [AW-1:0]          w_gsum;
    logic [AW-1:0]          w_lsum;
    logic [PW-1:0]          w_pm1;
    logic [NW-1:0]          w_gprod;
    logic [NW-1:0]          w_lprod;
    logic [NW-1:0]          w_rprod;
    logic [rsw_pkg::DEN_W-1:0] w_den;
    logic [PW+NW-1:0]       w_gstep;
    logic [PW+NW-1:0]       w_lstep;
    logic [rsw_pkg::DSH_W-1:0] w_rnum_ext;
    logic                   w_ge;
    logic                   w_div_last;

    // Warm-up sums, products and divider steps.
    assign w_gsum     = r_gavg + r_gx[AW-1:0];
    assign w_lsum     = r_lavg + r_lx[AW-1:0];
    assign w_pm1      = i_period - 1'b1;
    assign w_gprod    = NW'(r_gavg) * NW'(w_pm1);
    assign w_lprod    = NW'(r_lavg) * NW'(w_pm1);
    assign w_rprod    = NW'(r_gavg) * NW'(rsw_pkg::RSI_FULL);
    assign w_den      = {1'b0, r_gavg} + {1'b0, r_lavg};
    assign w_gstep    = div_step(r_gn, r_gr, i_period);
    assign w_lstep    = div_step(r_ln, r_lr, i_period);
    assign w_rnum_ext = rsw_pkg::DSH_W'(r_rnum);
    assign w_ge       = (w_rnum_ext >= r_rden);
    assign w_div_last = (r_cnt == rsw_pkg::CNT_W'(rsw_pkg::DIV_STEPS - 1));

    assign o_res_value = r_q;
    assign o_res_valid = r_vld;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsw_pkg::ST_IDLE: begin
                if (!i_cmd_status.empty) begin
                    case (i_kind)
                        rsw_pkg::KIND_FIRST:  n_state = rsw_pkg::ST_PUSH;
                        rsw_pkg::KIND_SMOOTH: n_state = rsw_pkg::ST_MUL;
                        default:              n_state = rsw_pkg::ST_SUM;
                    endcase
                end
            end
            rsw_pkg::ST_SUM: begin
                n_state = (r_kind == rsw_pkg::KIND_FINAL) ? rsw_pkg::ST_DIV : rsw_pkg::ST_PUSH;
            end
            rsw_pkg::ST_MUL:  n_state = rsw_pkg::ST_ADD;
            rsw_pkg::ST_ADD:  n_state = rsw_pkg::ST_DIV;
            rsw_pkg::ST_DIV: begin
                if (w_div_last) begin
                    n_state = rsw_pkg::ST_RMUL;
                end
            end
            rsw_pkg::ST_RMUL: begin
                n_state = (r_lavg == '0) ? rsw_pkg::ST_PUSH : rsw_pkg::ST_RDIV;
            end
            rsw_pkg::ST_RDIV: begin
                if (r_cnt == '0) begin
                    n_state = rsw_pkg::ST_PUSH;
                end
            end
            rsw_pkg::ST_PUSH: begin
                if (!i_res_status.full) begin
                    n_state = rsw_pkg::ST_IDLE;
                end
            end
            default: n_state = rsw_pkg::ST_IDLE;
        endcase
    end

    // Queue handshakes.
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            rsw_pkg::ST_IDLE: o_cmd_pop  = !i_cmd_status.empty;
            rsw_pkg::ST_PUSH: o_res_push = !i_res_status.full;
            default: begin
                o_cmd_pop  = 1'b0;
                o_res_push = 1'b0;
            end
        endcase
    end

    // State, averages and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsw_pkg::ST_IDLE;
            r_gavg  <= '0;
            r_lavg  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_restart) begin
                r_gavg <= '0;
                r_lavg <= '0;
            end else begin
                case (r_state)
                    rsw_pkg::ST_SUM: begin
                        r_gavg <= w_gsum;
                        r_lavg <= w_lsum;
                        r_cnt  <= '0;
                    end
                    rsw_pkg::ST_ADD: r_cnt <= '0;
                    rsw_pkg::ST_DIV: begin
                        r_cnt <= r_cnt + 1'b1;
                        if (w_div_last) begin
                            r_gavg <= w_gstep[AW-1:0];
                            r_lavg <= w_lstep[AW-1:0];
                        end
                    end
                    rsw_pkg::ST_RMUL: r_cnt <= rsw_pkg::CNT_W'(QB - 1);
                    rsw_pkg::ST_RDIV: r_cnt <= r_cnt - 1'b1;
                    default: r_cnt <= r_cnt;
                endcase
            end
        end
    end

    // Datapath registers of the two dividers and the result.
    always_ff @(posedge i_clk) begin
        case (r_state)
            rsw_pkg::ST_IDLE: begin
                r_kind <= i_kind;
                r_gx   <= NW'(i_gain) << FRAC_BITS;
                r_lx   <= NW'(i_loss) << FRAC_BITS;
                r_q    <= '0;
                r_vld  <= 1'b0;
            end
            rsw_pkg::ST_SUM: begin
                r_gn <= NW'(w_gsum);
                r_ln <= NW'(w_lsum);
                r_gr <= '0;
                r_lr <= '0;
            end
            rsw_pkg::ST_MUL: begin
                r_gn <= w_gprod;
                r_ln <= w_lprod;
            end
            rsw_pkg::ST_ADD: begin
                r_gn <= r_gn + r_gx;
                r_ln <= r_ln + r_lx;
                r_gr <= '0;
                r_lr <= '0;
            end
            rsw_pkg::ST_DIV: begin
                {r_gr, r_gn} <= w_gstep;
                {r_lr, r_ln} <= w_lstep;
            end
            rsw_pkg::ST_RMUL: begin
                r_rnum <= w_rprod;
                r_rden <= rsw_pkg::DSH_W'(w_den) << (QB - 1);
                r_vld  <= 1'b1;
                r_q    <= (r_lavg == '0) ? rsw_pkg::RSI_FULL : '0;
            end
            rsw_pkg::ST_RDIV: begin
                r_q    <= {r_q[QB-2:0], w_ge};
                r_rden <= r_rden >> 1;
                if (w_ge) begin
                    r_rnum <= NW'(w_rnum_ext - r_rden);
                end
            end
            default: r_q <= r_q;
        endcase
    end

endmodule

// ===== design/rsw_checker.sv =====
// Port-level checks for the RSI Wilder smoothing core, bound to its top level.
// Depends on rsw_pkg and rsi_wilder_smoothing_core.
`timescale 1ns / 1ps

module rsw_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           empty,
    input logic                           pop,
    input logic [rsw_pkg::RSI_Q_BITS-1:0] o_rsi_value,
    input logic                           o_rsi_valid
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // A shown result never exceeds the full scale.
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_rsi_value <= rsw_pkg::RSI_FULL))
        else $error("result value above full scale");

    // A result without a valid value carries zero.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_rsi_valid) |-> (o_rsi_value == '0))
        else $error("invalid result with nonzero value");

    // A waiting result that is not taken stays as it is.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_rsi_value) && $stable(o_rsi_valid)))
        else $error("stalled result changed");

endmodule

bind rsi_wilder_smoothing_core rsw_checker u_rsw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .empty       (empty),
    .pop         (pop),
    .o_rsi_value (o_rsi_value),
    .o_rsi_valid (o_rsi_valid)
);
